### rtl/rijt_pkg.sv
// ============================================================================
// RTP interarrival jitter table package
// Widths, scaling constants and the table access types shared by the block.
// ============================================================================
package rijt_pkg;

   localparam int NUM_STREAMS  = 16;
   localparam int STREAM_IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

   // Payload field widths.
   localparam int STREAM_W  = 4;
   localparam int STAMP_W   = 32;
   localparam int RATE_W    = 18;
   localparam int ARR_W     = 48;
   localparam int JIT_W     = 40;
   localparam int PKT_CNT_W = 32;

   // One million is 15625 times 64: the odd part is multiplied in serially and
   // the power of two is appended as zero bits of the dividend.
   localparam int US_SCALE_ODD   = 15625;
   localparam int US_SCALE_W     = $clog2(US_SCALE_ODD + 1);
   localparam int US_SCALE_SHIFT = 6;
   localparam int PROD_W         = STAMP_W + US_SCALE_W;
   localparam int DIVD_W         = PROD_W + US_SCALE_SHIFT;
   localparam int SCALE_BIT_W    = $clog2(US_SCALE_W);
   localparam int STEP_CNT_W     = $clog2(DIVD_W);

   localparam logic [US_SCALE_W-1:0] US_SCALE_K = US_SCALE_W'(US_SCALE_ODD);

   // Jitter arithmetic: four fraction bits and a gain of one sixteenth.
   localparam int JIT_FRAC  = 4;
   localparam int JIT_GAIN  = 4;
   localparam int DIFF_W    = DIVD_W + 2;
   localparam int MAG_W     = DIFF_W - 1;
   localparam int ACC_W     = MAG_W + JIT_FRAC;

   localparam logic [JIT_W-1:0]     JIT_MAX = '1;
   localparam logic [PKT_CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic                    first;
      logic [STAMP_W-1:0]      prev_rtp;
      logic [ARR_W-1:0]        prev_arr;
      logic [JIT_W-1:0]        jitter;
      logic [PKT_CNT_W-1:0]    count;
   } tbl_entry_type;

   typedef struct packed {
      logic                    en;
      logic [STREAM_IDX_W-1:0] idx;
      logic [STAMP_W-1:0]      rtp;
      logic [ARR_W-1:0]        arr;
      logic [JIT_W-1:0]        jitter;
      logic [PKT_CNT_W-1:0]    count;
   } tbl_write_type;

endpackage

### rtl/rijt_if.sv
// ============================================================================
// RTP interarrival jitter table channels
// Valid/ready channels for packet arrivals and for per-packet results.
// ============================================================================
interface rijt_req_if import rijt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STREAM_W-1:0] stream_index;
   logic                has_timestamp;
   logic [STAMP_W-1:0]  media_stamp;
   logic [RATE_W-1:0]   media_rate;
   logic [ARR_W-1:0]    arrival_time_us;

   modport source (output valid, stream_index, has_timestamp, media_stamp,
                   media_rate, arrival_time_us, input ready);
   modport sink   (input valid, stream_index, has_timestamp, media_stamp,
                   media_rate, arrival_time_us, output ready);
endinterface

interface rijt_rsp_if import rijt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [JIT_W-1:0]     jitter_q4;
   logic [PKT_CNT_W-1:0] stream_packets;
   logic [PKT_CNT_W-1:0] all_packets;
   logic                 timing_updated;

   modport source (output valid, jitter_q4, stream_packets, all_packets,
                   timing_updated, input ready);
   modport sink   (input valid, jitter_q4, stream_packets, all_packets,
                   timing_updated, output ready);
endinterface

### rtl/rijt_conv.sv
// ============================================================================
// RTP delta to microseconds converter
// Serial multiply by one million followed by a restoring divide by the rate,
// one bit per cycle.
// ============================================================================
module rijt_conv import rijt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [STAMP_W-1:0] delta,
   input  logic [RATE_W-1:0]  rate,
   output logic               done,
   output logic [DIVD_W-1:0]  quot
);

   typedef enum logic [2:0] {
      CV_IDLE = 3'b001,
      CV_MUL  = 3'b010,
      CV_DIV  = 3'b100
   } conv_state_type;

   conv_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    done_ff, done_in;
   logic [DIVD_W-1:0]       work_ff, work_in;
   logic [STAMP_W-1:0]      delta_ff, delta_in;
   logic [RATE_W-1:0]       rate_ff, rate_in;
   logic [RATE_W-1:0]       rem_ff, rem_in;
   logic [PROD_W-1:0]       prod_next;
   logic [RATE_W:0]         trial;
   logic                    fits;

   // Horner step over the bits of the scale constant, most significant first.
   always_comb begin
      prod_next = {work_ff[PROD_W-2:0], 1'b0};
      if (US_SCALE_K[cnt_ff[SCALE_BIT_W-1:0]]) begin
         prod_next = prod_next + PROD_W'(delta_ff);
      end
   end

   assign trial = {rem_ff, work_ff[DIVD_W-1]};
   assign fits  = (trial >= {1'b0, rate_ff});

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      work_in  = work_ff;
      delta_in = delta_ff;
      rate_in  = rate_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         CV_IDLE: begin
            if (start) begin
               delta_in = delta;
               rate_in  = rate;
               work_in  = '0;
               rem_in   = '0;
               cnt_in   = STEP_CNT_W'(US_SCALE_W - 1);
               state_in = CV_MUL;
            end
         end
         CV_MUL: begin
            work_in = DIVD_W'(prod_next);
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               work_in  = {prod_next, {US_SCALE_SHIFT{1'b0}}};
               cnt_in   = STEP_CNT_W'(DIVD_W - 1);
               state_in = CV_DIV;
            end
         end
         CV_DIV: begin
            // Dividend bits leave at the top while quotient bits enter below.
            work_in = {work_ff[DIVD_W-2:0], fits};
            rem_in  = fits ? RATE_W'(trial - {1'b0, rate_ff}) : trial[RATE_W-1:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = CV_IDLE;
            end
         end
         default: begin
            state_in = CV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      work_ff  <= work_in;
      delta_ff <= delta_in;
      rate_ff  <= rate_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign quot = work_ff;

endmodule

### rtl/rijt_table.sv
// ============================================================================
// RTP interarrival jitter stream table
// Per-stream timing state in registers, one read and one write port.
// ============================================================================
module rijt_table import rijt_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [STREAM_IDX_W-1:0] rd_idx,
   output tbl_entry_type           rd_entry,
   input  tbl_write_type           wr
);

   logic [NUM_STREAMS-1:0]  first_ff;
   logic [STAMP_W-1:0]      prev_rtp_ff [NUM_STREAMS];
   logic [ARR_W-1:0]        prev_arr_ff [NUM_STREAMS];
   logic [JIT_W-1:0]        jitter_ff   [NUM_STREAMS];
   logic [PKT_CNT_W-1:0]    count_ff    [NUM_STREAMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '1;
         for (int s = 0; s < NUM_STREAMS; s++) begin
            jitter_ff[s] <= '0;
            count_ff[s]  <= '0;
         end
      end else if (wr.en) begin
         first_ff[wr.idx]  <= 1'b0;
         jitter_ff[wr.idx] <= wr.jitter;
         count_ff[wr.idx]  <= wr.count;
      end
      // Previous stamps are only read once the stream has been written.
      if (wr.en) begin
         prev_rtp_ff[wr.idx] <= wr.rtp;
         prev_arr_ff[wr.idx] <= wr.arr;
      end
   end

   always_comb begin
      rd_entry.first    = first_ff[rd_idx];
      rd_entry.prev_rtp = prev_rtp_ff[rd_idx];
      rd_entry.prev_arr = prev_arr_ff[rd_idx];
      rd_entry.jitter   = jitter_ff[rd_idx];
      rd_entry.count    = count_ff[rd_idx];
   end

endmodule

### rtl/rtp_interarrival_jitter_table_unit.sv
// ============================================================================
// RTP interarrival jitter table unit
// Per-stream interarrival jitter estimator with saturating packet counters.
// ============================================================================
// Usage:
// One packet arrival is taken per beat on req_bus: stream index, RTP stamp
// with its presence flag, sample rate and arrival time in microseconds. For
// each beat exactly one result beat leaves on rsp_bus with the stream's
// jitter (Q.4 microseconds), its timed packet count, the overall packet count
// and whether timing state moved.
// A timed packet that follows an earlier one on its stream passes the look-up,
// the serial converter, which multiplies the RTP delta by one million and then
// divides it by the rate a bit at a time, the jitter update states (difference,
// magnitude, gap, step) and the handover to the output register. Untimed
// packets, first packets of a stream and out-of-range streams go from the
// look-up straight to the handover.
// One packet is worked on at a time; req_bus.ready is high only while idle, so
// no packet is taken before the last one's result is in the output register.
// The result sits in an output register, so a stalled receiver holds only that
// beat while the next packet is taken and worked on; the unit then waits with
// its finished result until the register frees.
// Synchronous reset marks every stream as awaiting its first timed packet and
// clears jitter and counters.
// ============================================================================
module rtp_interarrival_jitter_table_unit import rijt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   rijt_req_if.sink   req_bus,
   rijt_rsp_if.source rsp_bus
);

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_LOOK = 8'b0000_0010,
      ST_CONV = 8'b0000_0100,
      ST_DIFF = 8'b0000_1000,
      ST_ABS  = 8'b0001_0000,
      ST_GAP  = 8'b0010_0000,
      ST_STEP = 8'b0100_0000,
      ST_FIN  = 8'b1000_0000
   } unit_state_type;

   unit_state_type          state_ff, state_in;

   // Captured packet.
   logic [STREAM_W-1:0]     stream_ff;
   logic                    has_ts_ff;
   logic [STAMP_W-1:0]      rtp_ff;
   logic [RATE_W-1:0]       rate_ff;
   logic [ARR_W-1:0]        arr_ff;

   logic [PKT_CNT_W-1:0]    all_count_ff, all_count_in;
   logic                    timed_ff, timed_in;
   logic [JIT_W-1:0]        jit_ff, jit_in;
   logic [PKT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ARR_W:0]          arr_d_ff, arr_d_in;
   logic [DIFF_W-1:0]       diff_ff, diff_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [ACC_W-1:0]        gap_ff, gap_in;
   logic                    rise_ff, rise_in;

   logic                    rsp_valid_ff;
   logic [JIT_W-1:0]        rsp_jit_ff;
   logic [PKT_CNT_W-1:0]    rsp_cnt_ff;
   logic [PKT_CNT_W-1:0]    rsp_total_ff;
   logic                    rsp_upd_ff;

   logic                    req_take;
   logic                    rsp_free;
   logic                    in_range;
   logic                    timed_now;
   logic [STREAM_IDX_W-1:0] tbl_idx;
   tbl_entry_type           entry;
   tbl_write_type           tbl_wr;
   logic                    conv_start;
   logic                    conv_done;
   logic [DIVD_W-1:0]       conv_quot;
   logic [MAG_W-1:0]        mag;
   logic [ACC_W-1:0]        jit_wide;
   logic [ACC_W-1:0]        step_wide;
   logic [ACC_W-1:0]        moved;

   assign tbl_idx   = STREAM_IDX_W'(stream_ff);
   assign in_range  = (int'(stream_ff) < NUM_STREAMS);
   assign timed_now = in_range && has_ts_ff && (rate_ff != '0);

   rijt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (tbl_idx),
      .rd_entry (entry),
      .wr       (tbl_wr)
   );

   assign conv_start = (state_ff == ST_LOOK) && timed_now && !entry.first;

   rijt_conv u_conv (
      .clock (clock),
      .reset (reset),
      .start (conv_start),
      .delta (rtp_ff - entry.prev_rtp),
      .rate  (rate_ff),
      .done  (conv_done),
      .quot  (conv_quot)
   );

   assign req_take  = req_bus.valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;

   assign mag       = diff_ff[DIFF_W-1] ? MAG_W'(-diff_ff) : diff_ff[MAG_W-1:0];
   assign jit_wide  = ACC_W'(jit_ff);
   assign step_wide = gap_ff >> JIT_GAIN;
   assign moved     = rise_ff ? (jit_wide + step_wide) : (jit_wide - step_wide);

   always_comb begin
      state_in     = state_ff;
      all_count_in = all_count_ff;
      timed_in     = timed_ff;
      jit_in       = jit_ff;
      cnt_in       = cnt_ff;
      arr_d_in     = arr_d_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      gap_in       = gap_ff;
      rise_in      = rise_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (all_count_ff != CNT_MAX) begin
                  all_count_in = all_count_ff + 1'b1;
               end
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            timed_in = timed_now;
            jit_in   = in_range ? entry.jitter : '0;
            cnt_in   = in_range ? entry.count : '0;
            if (timed_now && (entry.count != CNT_MAX)) begin
               cnt_in = entry.count + 1'b1;
            end
            arr_d_in = {1'b0, arr_ff} - {1'b0, entry.prev_arr};
            state_in = conv_start ? ST_CONV : ST_FIN;
         end
         ST_CONV: begin
            if (conv_done) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            diff_in  = {{(DIFF_W-ARR_W-1){arr_d_ff[ARR_W]}}, arr_d_ff}
                       - DIFF_W'(conv_quot);
            state_in = ST_ABS;
         end
         ST_ABS: begin
            acc_in   = {mag, {JIT_FRAC{1'b0}}};
            state_in = ST_GAP;
         end
         ST_GAP: begin
            // Moving down rounds the step up so that the shift floors.
            rise_in  = (acc_ff >= jit_wide);
            gap_in   = (acc_ff >= jit_wide) ? (acc_ff - jit_wide)
                                            : (jit_wide - acc_ff + ACC_W'(15));
            state_in = ST_STEP;
         end
         ST_STEP: begin
            jit_in   = (moved > ACC_W'(JIT_MAX)) ? JIT_MAX : moved[JIT_W-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      tbl_wr.en     = (state_ff == ST_FIN) && rsp_free && timed_ff;
      tbl_wr.idx    = tbl_idx;
      tbl_wr.rtp    = rtp_ff;
      tbl_wr.arr    = arr_ff;
      tbl_wr.jitter = jit_ff;
      tbl_wr.count  = cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         all_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         all_count_ff <= all_count_in;
         if ((state_ff == ST_FIN) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         stream_ff <= req_bus.stream_index;
         has_ts_ff <= req_bus.has_timestamp;
         rtp_ff    <= req_bus.media_stamp;
         rate_ff   <= req_bus.media_rate;
         arr_ff    <= req_bus.arrival_time_us;
      end
      if ((state_ff == ST_FIN) && rsp_free) begin
         rsp_jit_ff   <= jit_ff;
         rsp_cnt_ff   <= cnt_ff;
         rsp_total_ff <= all_count_ff;
         rsp_upd_ff   <= timed_ff;
      end
      timed_ff <= timed_in;
      jit_ff   <= jit_in;
      cnt_ff   <= cnt_in;
      arr_d_ff <= arr_d_in;
      diff_ff  <= diff_in;
      acc_ff   <= acc_in;
      gap_ff   <= gap_in;
      rise_ff  <= rise_in;
   end

   assign req_bus.ready          = (state_ff == ST_IDLE);
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.jitter_q4      = rsp_jit_ff;
   assign rsp_bus.stream_packets = rsp_cnt_ff;
   assign rsp_bus.all_packets    = rsp_total_ff;
   assign rsp_bus.timing_updated = rsp_upd_ff;

   // The converter finishes only while the sequencer is waiting for it.
   a_conv_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> (state_ff == ST_CONV))
      else $error("converter finished outside its wait state");

   // A packet that moved timing state has been counted on its stream.
   a_updated_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_upd_ff) |-> (rsp_cnt_ff != '0))
      else $error("timing update reported with a zero stream count");

   // The overall packet counter never goes backwards.
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (all_count_ff >= $past(all_count_ff)))
      else $error("overall packet count decreased");

endmodule

### tb/tb_rijt_jitter_monitor.sv
// ============================================================================
// RTP interarrival jitter table monitor
// Watches the packet and result channels, keeps its own per-stream jitter
// table, predicts each result beat and compares it field by field.
// ============================================================================
module tb_rijt_jitter_monitor import rijt_pkg::*; (
   input  logic clock,
   input  logic reset,
   rijt_req_if  req_mon,
   rijt_rsp_if  rsp_mon,
   output int   fail_count,
   output int   awaiting_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_DEPTH = 8;

   typedef struct packed {
      logic [JIT_W-1:0]     jitter;
      logic [PKT_CNT_W-1:0] stream_pkts;
      logic [PKT_CNT_W-1:0] total;
      logic                 updated;
   } jitter_report_type;

   logic                 awaiting_first [NUM_STREAMS];
   logic [STAMP_W-1:0]   last_stamp     [NUM_STREAMS];
   logic [ARR_W-1:0]     last_arrival   [NUM_STREAMS];
   logic [JIT_W-1:0]     jitter_est     [NUM_STREAMS];
   logic [PKT_CNT_W-1:0] timed_count    [NUM_STREAMS];
   logic [PKT_CNT_W-1:0] packet_total;

   // Expected results in order of arrival, kept in a small ring.
   jitter_report_type report_ring [REPORT_DEPTH];
   int                ring_head, ring_tail, ring_used;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      fail_count++;
      $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   // Folds one accepted packet into the table and queues the result it owes.
   task automatic absorb_packet(input logic [STREAM_W-1:0] idx,
                                input logic                timed_flag,
                                input logic [STAMP_W-1:0]  stamp,
                                input logic [RATE_W-1:0]   rate,
                                input logic [ARR_W-1:0]    arrival);
      jitter_report_type  want;
      logic [STAMP_W-1:0] stamp_delta;
      logic [63:0]        media_us, magnitude, target, cur, nxt;
      longint             arrival_delta, transit;
      if (packet_total != CNT_MAX) packet_total++;
      want       = '0;
      want.total = packet_total;
      if (idx < NUM_STREAMS) begin
         if (timed_flag && rate != '0) begin
            want.updated = 1'b1;
            if (timed_count[idx] != CNT_MAX) timed_count[idx]++;
            if (awaiting_first[idx]) begin
               awaiting_first[idx] = 1'b0;
            end else begin
               stamp_delta   = stamp - last_stamp[idx];
               media_us      = (64'(stamp_delta) * 64'd1000000) / 64'(rate);
               arrival_delta = longint'({16'd0, arrival})
                             - longint'({16'd0, last_arrival[idx]});
               transit       = arrival_delta - longint'(media_us);
               magnitude     = (transit < 0) ? -transit : transit;
               target        = magnitude << JIT_FRAC;
               cur           = 64'(jitter_est[idx]);
               // Moving down rounds the step up, which is a floor shift of a
               // negative difference.
               if (target >= cur) begin
                  nxt = cur + ((target - cur) >> JIT_GAIN);
               end else begin
                  nxt = cur - ((cur - target + ((64'd1 << JIT_GAIN) - 1)) >> JIT_GAIN);
               end
               if (nxt > 64'(JIT_MAX)) nxt = 64'(JIT_MAX);
               jitter_est[idx] = nxt[JIT_W-1:0];
            end
            last_stamp[idx]   = stamp;
            last_arrival[idx] = arrival;
         end
         want.jitter      = jitter_est[idx];
         want.stream_pkts = timed_count[idx];
      end
      if (ring_used == REPORT_DEPTH) begin
         flag_mismatch("more results outstanding than the unit can hold",
                       64'(ring_used), 64'(REPORT_DEPTH));
      end else begin
         report_ring[ring_tail] = want;
         ring_tail = (ring_tail + 1) % REPORT_DEPTH;
         ring_used++;
      end
   endtask

   task automatic check_report();
      jitter_report_type want;
      if (ring_used == 0) begin
         flag_mismatch("result beat with nothing outstanding",
                       64'(rsp_mon.all_packets), 64'd0);
      end else begin
         want      = report_ring[ring_head];
         ring_head = (ring_head + 1) % REPORT_DEPTH;
         ring_used--;
         if (rsp_mon.jitter_q4 !== want.jitter)
            flag_mismatch("jitter_q4", 64'(rsp_mon.jitter_q4), 64'(want.jitter));
         if (rsp_mon.stream_packets !== want.stream_pkts)
            flag_mismatch("stream_packets", 64'(rsp_mon.stream_packets),
                          64'(want.stream_pkts));
         if (rsp_mon.all_packets !== want.total)
            flag_mismatch("all_packets", 64'(rsp_mon.all_packets),
                          64'(want.total));
         if (rsp_mon.timing_updated !== want.updated)
            flag_mismatch("timing_updated", 64'(rsp_mon.timing_updated),
                          64'(want.updated));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_STREAMS; s++) begin
            awaiting_first[s] = 1'b1;
            last_stamp[s]     = '0;
            last_arrival[s]   = '0;
            jitter_est[s]     = '0;
            timed_count[s]    = '0;
         end
         packet_total = '0;
         ring_head    = 0;
         ring_tail    = 0;
         ring_used    = 0;
      end else begin
         // A result always belongs to an earlier packet, so it is checked first.
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) check_report();
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            absorb_packet(req_mon.stream_index, req_mon.has_timestamp,
                          req_mon.media_stamp, req_mon.media_rate,
                          req_mon.arrival_time_us);
         end
      end
      awaiting_count = ring_used;
   end

endmodule

### tb/tb_rtp_interarrival_jitter_table_unit.sv
// ============================================================================
// RTP interarrival jitter table unit testbench
// Drives directed corner packets and then paced per-stream RTP traffic mixed
// with untimed and random packets, under bursty sending and a stalling
// receiver; the monitor beside the unit checks every result beat.
// ============================================================================
module tb_rtp_interarrival_jitter_table_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rijt_pkg::*;

   localparam int RANDOM_PACKETS = 830;
   localparam int QUIET_LIMIT    = 3000;
   localparam int LONG_HOLD      = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, awaiting_count;

   rijt_req_if req_bus ();
   rijt_rsp_if rsp_bus ();

   rtp_interarrival_jitter_table_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   tb_rijt_jitter_monitor jitter_watch (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .fail_count     (fail_count),
      .awaiting_count (awaiting_count)
   );

   always #6 clock = ~clock;

   // Traffic generator state: each stream runs on an ideal media clock.
   logic [RATE_W-1:0]  gen_rate   [NUM_STREAMS];
   logic [STAMP_W-1:0] gen_stamp  [NUM_STREAMS];
   logic [ARR_W-1:0]   gen_clock  [NUM_STREAMS];
   int unsigned        gen_wobble [NUM_STREAMS];
   logic [ARR_W-1:0]   now_us;
   int  sent_count, paced_sent, untimed_sent, noise_sent, quiet_cycles;
   bit  holding_off, hold_done;

   function automatic logic [RATE_W-1:0] pick_rate();
      case ($urandom_range(5, 0))
         0:       return RATE_W'(8000);
         1:       return RATE_W'(16000);
         2:       return RATE_W'(44100);
         3:       return RATE_W'(48000);
         4:       return RATE_W'(90000);
         default: return RATE_W'($urandom_range(262143, 1));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_packet(input logic [STREAM_W-1:0] idx,
                              input logic                ts,
                              input logic [STAMP_W-1:0]  stamp,
                              input logic [RATE_W-1:0]   rate,
                              input logic [ARR_W-1:0]    arrival);
      req_bus.valid           <= 1'b1;
      req_bus.stream_index    <= idx;
      req_bus.has_timestamp   <= ts;
      req_bus.media_stamp     <= stamp;
      req_bus.media_rate      <= rate;
      req_bus.arrival_time_us <= arrival;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_paced_packet();
      logic [STREAM_W-1:0] s;
      logic [63:0]         samples;
      s = STREAM_W'($urandom_range(NUM_STREAMS - 1, 0));
      now_us += ($urandom_range(9, 0) == 0) ? $urandom_range(2000000, 0)
                                            : $urandom_range(20000, 0);
      if ($urandom_range(49, 0) == 0) gen_rate[s] = pick_rate();
      samples = (64'(now_us - gen_clock[s]) * 64'(gen_rate[s])) / 64'd1000000;
      gen_stamp[s] += samples[STAMP_W-1:0];
      gen_clock[s]  = now_us;
      paced_sent++;
      send_packet(s, 1'b1, gen_stamp[s], gen_rate[s],
                  now_us + ARR_W'($urandom_range(gen_wobble[s], 0)));
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (awaiting_count != 0);
   endtask

   // Watchdog: ends the run when neither channel moves for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("No beat moved for %0d cycles", QUIET_LIMIT);
         $display("rtp_interarrival_jitter_table_unit regression: fail");
         $finish;
      end
   end

   // Result side: segments of steady, random and sparse readiness, plus one
   // long hold-off once the traffic is well under way.
   initial begin
      int seg_left, mode;
      rsp_bus.ready = 1'b0;
      seg_left = 0;
      mode     = 0;
      @(negedge clock);
      forever begin
         if (!hold_done && sent_count >= 300) begin
            holding_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            holding_off = 1'b0;
            hold_done   = 1'b1;
         end
         if (seg_left == 0) begin
            seg_left = $urandom_range(120, 20);
            mode     = $urandom_range(2, 0);
         end
         seg_left--;
         case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= 1'($urandom_range(1, 0));
            default: rsp_bus.ready <= ($urandom_range(3, 0) == 0);
         endcase
         @(negedge clock);
      end
   end

   initial begin
      int burst_left, gap, kind;
      req_bus.valid           = 1'b0;
      req_bus.stream_index    = '0;
      req_bus.has_timestamp   = 1'b0;
      req_bus.media_stamp     = '0;
      req_bus.media_rate      = '0;
      req_bus.arrival_time_us = '0;
      now_us = {16'($urandom), 32'($urandom)};
      for (int s = 0; s < NUM_STREAMS; s++) begin
         gen_rate[s]   = pick_rate();
         gen_clock[s]  = now_us;
         gen_wobble[s] = $urandom_range(5000, 0);
         // Half the streams start just short of the timestamp wrap.
         gen_stamp[s]  = (s % 2 == 0) ? 32'hFFFF_FFFF - $urandom_range(3000000, 0)
                                      : 32'($urandom);
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Untimed packets before and after timing starts, first packets, a
      // timestamp wrap, arrival going backwards and jitter saturation.
      send_packet(4'd0,  1'b0, 32'h1234_5678, 18'd48000,  48'd500);
      send_packet(4'd0,  1'b1, 32'hFFFF_FFF0, 18'd0,      48'd600);
      send_packet(4'd0,  1'b1, 32'hFFFF_FFF0, 18'd48000,  48'd1000);
      send_packet(4'd0,  1'b1, 32'h0000_0020, 18'd48000,  48'd2000);
      send_packet(4'd0,  1'b1, 32'h0000_0200, 18'd48000,  48'd12500);
      send_packet(4'd0,  1'b1, 32'h0000_03E0, 18'd48000,  48'd100);
      send_packet(4'd0,  1'b0, 32'h0000_0000, 18'd0,      48'd200);
      send_packet(4'd15, 1'b1, 32'h0000_0000, 18'h3FFFF,  48'hFFFF_FFFF_FFFF);
      send_packet(4'd15, 1'b1, 32'hFFFF_FFFF, 18'd1,      48'd0);
      send_packet(4'd15, 1'b1, 32'h7FFF_FFFF, 18'd1,      48'd0);
      send_packet(4'd15, 1'b1, 32'h7FFF_FFFF, 18'd1,      48'd0);
      send_packet(4'd15, 1'b0, 32'hFFFF_FFFF, 18'h3FFFF,  48'hFFFF_FFFF_FFFF);
      send_packet(4'd7,  1'b1, 32'hAAAA_AAAA, 18'h2AAAA,  48'h5555_5555_5555);
      send_packet(4'd7,  1'b1, 32'h5555_5555, 18'h15555,  48'hAAAA_AAAA_AAAA);
      send_packet(4'd8,  1'b1, 32'd0,         18'd8000,   48'd0);
      send_packet(4'd8,  1'b1, 32'd160,       18'd8000,   48'd20000);
      send_packet(4'd8,  1'b1, 32'd320,       18'd8000,   48'd40001);
      send_packet(4'd9,  1'b1, 32'd1000,      18'd1,      48'd5);
      drain_results();

      burst_left = 0;
      for (int i = 0; i < RANDOM_PACKETS; i++) begin
         if (burst_left == 0) begin
            burst_left = ($urandom_range(4, 0) == 0) ? 60 : $urandom_range(24, 1);
            gap        = $urandom_range(12, 0);
            if (!holding_off && gap != 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         burst_left--;
         if (i == RANDOM_PACKETS / 2) drain_results();
         kind = $urandom_range(99, 0);
         if (kind < 75) begin
            send_paced_packet();
         end else if (kind < 87) begin
            untimed_sent++;
            if ($urandom_range(1, 0) == 1) begin
               send_packet(STREAM_W'($urandom), 1'b0, 32'($urandom),
                           RATE_W'($urandom), now_us);
            end else begin
               send_packet(STREAM_W'($urandom), 1'b1, 32'($urandom), '0, now_us);
            end
         end else begin
            noise_sent++;
            send_packet(STREAM_W'($urandom), 1'($urandom), 32'($urandom),
                        RATE_W'($urandom_range(262143, 0)),
                        {16'($urandom), 32'($urandom)});
         end
      end
      drain_results();
      repeat (80) @(negedge clock);

      $display("Sent %0d packets: %0d paced stream packets, %0d untimed, %0d random,",
               sent_count, paced_sent, untimed_sent, noise_sent);
      $display("with bursty sending, a %0d-cycle result stall and three full drains.",
               LONG_HOLD);
      if (awaiting_count != 0) begin
         $display("%0d expected results never arrived", awaiting_count);
      end
      if (fail_count == 0 && awaiting_count == 0) begin
         $display("rtp_interarrival_jitter_table_unit regression: pass");
      end else begin
         $display("rtp_interarrival_jitter_table_unit regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/rijt_pkg.sv
rtl/rijt_if.sv
rtl/rijt_conv.sv
rtl/rijt_table.sv
rtl/rtp_interarrival_jitter_table_unit.sv
tb/tb_rijt_jitter_monitor.sv
tb/tb_rtp_interarrival_jitter_table_unit.sv
